### hw/rtl/sbtu_pkg.sv
// Shared types, constants and the lerp rounding helper of the bilinear tile upscaler.
// No dependencies; imported by sbtu_tile_mem and separable_bilinear_tile_upscaler.
package sbtu_pkg;

  localparam int unsigned MaxTileDef  = 64;
  localparam int unsigned MaxScaleDef = 4;
  localparam int unsigned FracBitsDef = 10;

  localparam int unsigned SampleW = 16;
  localparam int unsigned WeightW = 11;
  localparam int unsigned DiffW   = SampleW + 1;
  localparam int unsigned ProdW   = DiffW + WeightW + 1;

  typedef enum logic [1:0] {
    CMD_LOAD_H      = 2'd0,
    CMD_LOAD_V      = 2'd1,
    CMD_LOAD_SAMPLE = 2'd2,
    CMD_COMPUTE     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BOUNDS  = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_TILE_WIDTH  = 2'd0,
    REG_TILE_HEIGHT = 2'd1,
    REG_SCALE       = 2'd2,
    REG_RESIDUAL    = 2'd3
  } reg_e;

  typedef struct packed {
    logic [5:0]         near_idx;
    logic [5:0]         far_idx;
    logic [WeightW-1:0] weight;
  } coef_t;

  // Round the scaled difference, floor-shift it and add the near sample, wrapping to 16 bits.
  function automatic logic signed [SampleW-1:0] lerp_finish(
    input logic signed [SampleW-1:0] a,
    input logic signed [ProdW-1:0]   p,
    input int unsigned               frac_bits
  );
    logic signed [ProdW:0] half;
    logic signed [ProdW:0] sum;
    logic signed [ProdW:0] res;
    half = (ProdW + 1)'(1) <<< (frac_bits - 1);
    sum  = (ProdW + 1)'(p) + half;
    res  = (sum >>> frac_bits) + (ProdW + 1)'(a);
    return res[SampleW-1:0];
  endfunction

endpackage

### hw/rtl/sbtu_tile_mem.sv
// Source tile store: one write port and two registered read ports.
// Depends on sbtu_pkg for the sample width.
module sbtu_tile_mem
  import sbtu_pkg::*;
#(
  parameter int unsigned AddrW = 12
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  logic [SampleW-1:0]   wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_a_i,
  input  logic [AddrW-1:0]     raddr_b_i,
  output logic [SampleW-1:0]   rdata_a_o,
  output logic [SampleW-1:0]   rdata_b_o
);

  logic [SampleW-1:0] mem [2**AddrW];
  logic [SampleW-1:0] rdata_a_q, rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Hold read data while the pipeline stalls.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### hw/rtl/separable_bilinear_tile_upscaler.sv
// Separable bilinear tile upscaler: top level, six-stage pipeline.
// Throughput: one item per cycle while the output register is not stalled.
// All stages advance together whenever the output register is empty or being drained.
// Reset clears valid bits and configuration (width 64, height 64, scale 2, plain mode);
// coefficient tables and the source tile are undefined until loaded.
// Depends on sbtu_pkg and sbtu_tile_mem.
module separable_bilinear_tile_upscaler
  import sbtu_pkg::*;
#(
  parameter int unsigned MAX_TILE  = MaxTileDef,
  parameter int unsigned MAX_SCALE = MaxScaleDef,
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // col[7:0], row[15:8], near_index[21:16], far_index[27:22], weight[38:28],
  // sample[54:39], prediction[62:55], zero[63]
  input  logic [63:0] s_axis_tdata_i,
  // cmd[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // out_pixel[7:0], status[9:8], zero[15:10]
  output logic [15:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i
);

  localparam int unsigned CoefDepth = MAX_TILE * MAX_SCALE;
  localparam int unsigned CoefW     = $clog2(CoefDepth);
  localparam int unsigned TileW     = $clog2(MAX_TILE);

  // configuration
  logic [6:0] tile_width_q, tile_height_q;
  logic [2:0] scale_q;
  logic       residual_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_width_q  <= 7'd64;
      tile_height_q <= 7'd64;
      scale_q       <= 3'd2;
      residual_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_TILE_WIDTH:  tile_width_q  <= cfg_data_i;
        REG_TILE_HEIGHT: tile_height_q <= cfg_data_i;
        REG_SCALE:       scale_q       <= cfg_data_i[2:0];
        REG_RESIDUAL:    residual_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [6:0] w_sat, h_sat;
  logic [2:0] s_sat;
  logic [9:0] w_out, h_out;

  always_comb begin
    w_sat = tile_width_q;
    if (tile_width_q == 7'd0) w_sat = 7'd1;
    else if (tile_width_q > 7'(MAX_TILE)) w_sat = 7'(MAX_TILE);
    h_sat = tile_height_q;
    if (tile_height_q == 7'd0) h_sat = 7'd1;
    else if (tile_height_q > 7'(MAX_TILE)) h_sat = 7'(MAX_TILE);
    s_sat = scale_q;
    if (scale_q < 3'd2) s_sat = 3'd2;
    else if (scale_q > 3'(MAX_SCALE)) s_sat = 3'(MAX_SCALE);
    w_out = 10'(w_sat) * 10'(s_sat);
    h_out = 10'(h_sat) * 10'(s_sat);
  end

  // input unpack
  cmd_e               in_cmd;
  logic [7:0]         in_col, in_row, in_pred;
  logic [5:0]         in_near, in_far;
  logic [WeightW-1:0] in_weight;
  logic [SampleW-1:0] in_sample;

  assign in_cmd    = cmd_e'(s_axis_tuser_i);
  assign in_col    = s_axis_tdata_i[7:0];
  assign in_row    = s_axis_tdata_i[15:8];
  assign in_near   = s_axis_tdata_i[21:16];
  assign in_far    = s_axis_tdata_i[27:22];
  assign in_weight = s_axis_tdata_i[38:28];
  assign in_sample = s_axis_tdata_i[54:39];
  assign in_pred   = s_axis_tdata_i[62:55];

  logic m_valid_q;
  logic adv, acc;

  assign adv             = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign acc             = s_axis_tvalid_i && adv;

  // stage 0: bounds checks, coefficient table access
  logic col_coef_ok, smp_ok, out_ok;
  logic st0_good;
  status_e st0_status;

  always_comb begin
    col_coef_ok = {2'b0, in_col} < 10'(CoefDepth);
    smp_ok      = ({2'b0, in_col} < 10'(MAX_TILE)) && ({2'b0, in_row} < 10'(MAX_TILE));
    out_ok      = ({2'b0, in_col} < w_out) && ({2'b0, in_row} < h_out);
    st0_good    = 1'b0;
    st0_status  = ST_OK;
    case (in_cmd)
      CMD_LOAD_H, CMD_LOAD_V: if (!col_coef_ok) st0_status = ST_IGNORED;
      CMD_LOAD_SAMPLE:        if (!smp_ok) st0_status = ST_IGNORED;
      CMD_COMPUTE: begin
        if (out_ok) st0_good = 1'b1;
        else st0_status = ST_BOUNDS;
      end
      default: ;
    endcase
  end

  coef_t hmem [CoefDepth];
  coef_t vmem [CoefDepth];
  coef_t hc1_q, vc1_q;
  coef_t in_coef;

  assign in_coef = '{near_idx: in_near, far_idx: in_far, weight: in_weight};

  always_ff @(posedge clk_i) begin
    if (acc && in_cmd == CMD_LOAD_H && col_coef_ok) begin
      hmem[in_col[CoefW-1:0]] <= in_coef;
    end
    if (acc && in_cmd == CMD_LOAD_V && col_coef_ok) begin
      vmem[in_col[CoefW-1:0]] <= in_coef;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hc1_q <= hmem[in_col[CoefW-1:0]];
      vc1_q <= vmem[in_row[CoefW-1:0]];
    end
  end

  logic    v1_q, good1_q;
  status_e st1_q;
  logic [7:0] pred1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      good1_q <= st0_good;
      st1_q   <= st0_status;
      pred1_q <= in_pred;
    end
  end

  // stage 1: near bounds, far clamp, tile read
  logic [6:0]       xr, yb;
  logic             near_ok;
  logic [TileW-1:0] xl_a, xr_a, yt_a, yb_a;

  always_comb begin
    near_ok = ({1'b0, hc1_q.near_idx} < w_sat) && ({1'b0, vc1_q.near_idx} < h_sat);
    xr = ({1'b0, hc1_q.far_idx} < w_sat - 7'd1) ? {1'b0, hc1_q.far_idx} : w_sat - 7'd1;
    yb = ({1'b0, vc1_q.far_idx} < h_sat - 7'd1) ? {1'b0, vc1_q.far_idx} : h_sat - 7'd1;
    xl_a = hc1_q.near_idx[TileW-1:0];
    yt_a = vc1_q.near_idx[TileW-1:0];
    xr_a = xr[TileW-1:0];
    yb_a = yb[TileW-1:0];
  end

  logic                 smp_we;
  logic [2*TileW-1:0]   smp_waddr;
  logic [SampleW-1:0]   tl_raw, tr_raw, bl_raw, br_raw;

  assign smp_we    = acc && in_cmd == CMD_LOAD_SAMPLE && smp_ok;
  assign smp_waddr = {in_row[TileW-1:0], in_col[TileW-1:0]};

  sbtu_tile_mem #(.AddrW(2 * TileW)) u_top_mem (
    .clk_i     (clk_i),
    .we_i      (smp_we),
    .waddr_i   (smp_waddr),
    .wdata_i   (in_sample),
    .re_i      (adv),
    .raddr_a_i ({yt_a, xl_a}),
    .raddr_b_i ({yt_a, xr_a}),
    .rdata_a_o (tl_raw),
    .rdata_b_o (tr_raw)
  );

  sbtu_tile_mem #(.AddrW(2 * TileW)) u_bot_mem (
    .clk_i     (clk_i),
    .we_i      (smp_we),
    .waddr_i   (smp_waddr),
    .wdata_i   (in_sample),
    .re_i      (adv),
    .raddr_a_i ({yb_a, xl_a}),
    .raddr_b_i ({yb_a, xr_a}),
    .rdata_a_o (bl_raw),
    .rdata_b_o (br_raw)
  );

  logic               v2_q, good2_q;
  status_e            st2_q;
  logic [7:0]         pred2_q;
  logic [WeightW-1:0] hw2_q, vw2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      good2_q <= good1_q && near_ok;
      st2_q   <= (good1_q && !near_ok) ? ST_BOUNDS : st1_q;
      pred2_q <= pred1_q;
      hw2_q   <= hc1_q.weight;
      vw2_q   <= vc1_q.weight;
    end
  end

  // stage 2: horizontal products
  logic signed [SampleW-1:0] tl_s, tr_s, bl_s, br_s;
  logic signed [DiffW-1:0]   dt, db;
  logic signed [ProdW-1:0]   pt_d, pb_d;

  always_comb begin
    if (residual_q) begin
      tl_s = signed'(tl_raw);
      tr_s = signed'(tr_raw);
      bl_s = signed'(bl_raw);
      br_s = signed'(br_raw);
    end else begin
      tl_s = signed'({8'd0, tl_raw[7:0]});
      tr_s = signed'({8'd0, tr_raw[7:0]});
      bl_s = signed'({8'd0, bl_raw[7:0]});
      br_s = signed'({8'd0, br_raw[7:0]});
    end
    dt   = DiffW'(tr_s) - DiffW'(tl_s);
    db   = DiffW'(br_s) - DiffW'(bl_s);
    pt_d = ProdW'(dt) * signed'(ProdW'({1'b0, hw2_q}));
    pb_d = ProdW'(db) * signed'(ProdW'({1'b0, hw2_q}));
  end

  logic                      v3_q, good3_q;
  status_e                   st3_q;
  logic [7:0]                pred3_q;
  logic [WeightW-1:0]        vw3_q;
  logic signed [ProdW-1:0]   pt3_q, pb3_q;
  logic signed [SampleW-1:0] tl3_q, bl3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      good3_q <= good2_q;
      st3_q   <= st2_q;
      pred3_q <= pred2_q;
      vw3_q   <= vw2_q;
      pt3_q   <= pt_d;
      pb3_q   <= pb_d;
      tl3_q   <= tl_s;
      bl3_q   <= bl_s;
    end
  end

  // stage 3: finish horizontal lerps
  logic                      v4_q, good4_q;
  status_e                   st4_q;
  logic [7:0]                pred4_q;
  logic [WeightW-1:0]        vw4_q;
  logic signed [SampleW-1:0] top4_q, bot4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      good4_q <= good3_q;
      st4_q   <= st3_q;
      pred4_q <= pred3_q;
      vw4_q   <= vw3_q;
      top4_q  <= lerp_finish(tl3_q, pt3_q, FRAC_BITS);
      bot4_q  <= lerp_finish(bl3_q, pb3_q, FRAC_BITS);
    end
  end

  // stage 4: vertical product
  logic signed [DiffW-1:0] dv;
  logic signed [ProdW-1:0] pv_d;

  always_comb begin
    dv   = DiffW'(bot4_q) - DiffW'(top4_q);
    pv_d = ProdW'(dv) * signed'(ProdW'({1'b0, vw4_q}));
  end

  logic                      v5_q, good5_q;
  status_e                   st5_q;
  logic [7:0]                pred5_q;
  logic signed [ProdW-1:0]   pv5_q;
  logic signed [SampleW-1:0] top5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      good5_q <= good4_q;
      st5_q   <= st4_q;
      pred5_q <= pred4_q;
      pv5_q   <= pv_d;
      top5_q  <= top4_q;
    end
  end

  // stage 5: vertical lerp, then residual add and clip in residual mode
  logic signed [SampleW-1:0] vres;
  logic signed [SampleW+1:0] rsum;
  logic [7:0]                pix_d;

  always_comb begin
    vres = lerp_finish(top5_q, pv5_q, FRAC_BITS);
    rsum = signed'({10'd0, pred5_q}) + (SampleW + 2)'(vres);
    if (!good5_q) begin
      pix_d = 8'd0;
    end else if (residual_q) begin
      if (rsum < 0) pix_d = 8'd0;
      else if (rsum > 18'sd255) pix_d = 8'd255;
      else pix_d = rsum[7:0];
    end else begin
      pix_d = vres[7:0];
    end
  end

  logic [7:0] m_pix_q;
  status_e    m_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_pix_q <= pix_d;
      m_st_q  <= st5_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {6'd0, m_st_q, m_pix_q};

endmodule
